// ===== sv/sgn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgn_pkg - shared types and constants of the sequence-gap NACK generator
// Result kinds, request codes, register indexes, the command that travels
// from the front part to the back part, and the back part's states.
// ----------------------------------------------------------------------------
package sgn_pkg;

    typedef enum logic [1:0] {
        REQ_DATA   = 2'd0,
        REQ_FINISH = 2'd1,
        REQ_START  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        KIND_NACK   = 3'd0,
        KIND_ACCEPT = 3'd1,
        KIND_DROP   = 3'd2,
        KIND_END    = 3'd3,
        KIND_START  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        REG_SESSION  = 2'd0,
        REG_XFER     = 2'd1,
        REG_CHUNK    = 2'd2,
        REG_RESERVED = 2'd3
    } t_reg_idx;

    localparam logic [15:0] CHUNK_LEN_RESET = 16'd1460;

    // One classified transaction: final kind, gap to report and counters after it
    typedef struct packed {
        t_kind       kind;
        logic [31:0] gap_from;
        logic [31:0] gap_len;
        logic [31:0] pkts;
        logic [31:0] bytes;
    } t_cmd;

    typedef enum logic {
        ST_LOAD,
        ST_RUN
    } t_bstate;

endpackage

// ===== sv/sgn_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgn_queue - two-entry command queue
// Decouples the classifying front part from the result-emitting back part.
// ----------------------------------------------------------------------------
module sgn_queue
    import sgn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       n_wptr;
    logic       n_rptr;
    logic [1:0] n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_comb begin
        n_wptr = i_push ? ~r_wptr : r_wptr;
        n_rptr = i_pop ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== sv/sgn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgn_front - request classifier
// Checks session and offset, updates the expected offset and the session
// counters, and queues one command per data, finish or start request for the back part.
// ----------------------------------------------------------------------------
module sgn_front
    import sgn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_pkt_session,
    input  logic [31:0] i_pkt_seq,
    input  logic [15:0] i_pkt_len,
    input  logic [31:0] i_expected_session,
    input  logic [31:0] i_transfer_size,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [31:0] r_offset;
    logic [31:0] r_pkts;
    logic [31:0] r_bytes;
    logic [31:0] n_offset;
    logic [31:0] n_pkts;
    logic [31:0] n_bytes;
    logic        w_accept;
    t_req        w_req;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;
    assign w_req    = t_req'(i_req_type);

    always_comb begin
        n_offset       = r_offset;
        n_pkts         = r_pkts;
        n_bytes        = r_bytes;
        o_push         = 1'b0;
        o_cmd.kind     = KIND_DROP;
        o_cmd.gap_from = r_offset;
        o_cmd.gap_len  = 32'd0;
        unique case (w_req)
            REQ_DATA: begin
                o_push = w_accept;
                if (i_pkt_session == i_expected_session && i_pkt_seq >= r_offset) begin
                    o_cmd.kind    = KIND_ACCEPT;
                    o_cmd.gap_len = i_pkt_seq - r_offset;
                    n_offset      = i_pkt_seq + 32'(i_pkt_len);
                    n_pkts        = r_pkts + 32'd1;
                    n_bytes       = r_bytes + 32'(i_pkt_len);
                end
            end
            REQ_FINISH: begin
                o_push     = w_accept;
                o_cmd.kind = KIND_END;
                if (i_transfer_size > r_offset) begin
                    o_cmd.gap_len = i_transfer_size - r_offset;
                end
            end
            REQ_START: begin
                o_push     = w_accept;
                o_cmd.kind = KIND_START;
                n_offset   = 32'd0;
                n_pkts     = 32'd0;
                n_bytes    = 32'd0;
            end
            REQ_NONE: begin
                // unused request: drop without a result
                o_push = 1'b0;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
        o_cmd.pkts  = n_pkts;
        o_cmd.bytes = n_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= 32'd0;
            r_pkts   <= 32'd0;
            r_bytes  <= 32'd0;
        end else if (w_accept) begin
            r_offset <= n_offset;
            r_pkts   <= n_pkts;
            r_bytes  <= n_bytes;
        end
    end

endmodule

// ===== sv/sgn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgn_back - NACK range emitter
// Takes one command from the queue, cuts its gap into chunk-sized NACK
// ranges, then emits the closing result into the output register.
// ----------------------------------------------------------------------------
module sgn_back
    import sgn_pkg::*;
#(
    parameter int MAX_NACKS_PER_ITEM = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_chunk_len,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_result_kind,
    output logic [31:0] o_range_start,
    output logic [15:0] o_range_len,
    output logic        o_nack_overflow,
    output logic        o_last_of_run,
    output logic [31:0] o_packet_count,
    output logic [31:0] o_byte_count
);

    localparam int CntW  = $clog2(MAX_NACKS_PER_ITEM + 1);
    localparam int SpanW = 16 + CntW;

    t_bstate        r_state;
    t_bstate        n_state;
    logic [CntW-1:0] r_cnt;
    logic [31:0]    r_pos;
    logic [31:0]    r_rem;
    logic           r_ovf;
    t_kind          r_kind;
    logic [31:0]    r_pkts;
    logic [31:0]    r_bytes;

    logic           r_out_valid;
    t_kind          r_out_kind;
    logic [31:0]    r_out_start;
    logic [15:0]    r_out_len;
    logic           r_out_ovf;
    logic           r_out_last;
    logic [31:0]    r_out_pkts;
    logic [31:0]    r_out_bytes;

    logic [15:0]    w_chunk;
    logic [SpanW-1:0] w_span;
    logic           w_ovf;
    logic           w_more;
    logic           w_out_free;
    logic           w_emit_nack;
    logic           w_emit_final;
    logic [15:0]    w_nack_len;

    // a zero chunk length behaves as one byte
    assign w_chunk    = (i_chunk_len == 16'd0) ? 16'd1 : i_chunk_len;
    assign w_span     = SpanW'(w_chunk) * SpanW'(MAX_NACKS_PER_ITEM);
    assign w_ovf      = i_q_cmd.gap_len > 32'(w_span);
    assign w_more     = (r_rem != 32'd0) && (r_cnt < CntW'(MAX_NACKS_PER_ITEM));
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_nack_len = (r_rem < 32'(w_chunk)) ? r_rem[15:0] : w_chunk;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (i_q_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_out_free && !w_more) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        o_pop        = 1'b0;
        w_emit_nack  = 1'b0;
        w_emit_final = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_pop = i_q_valid;
            end
            ST_RUN: begin
                w_emit_nack  = w_out_free && w_more;
                w_emit_final = w_out_free && !w_more;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit_nack || w_emit_final) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cnt   <= '0;
            r_pos   <= i_q_cmd.gap_from;
            r_rem   <= i_q_cmd.gap_len;
            r_ovf   <= w_ovf;
            r_kind  <= i_q_cmd.kind;
            r_pkts  <= i_q_cmd.pkts;
            r_bytes <= i_q_cmd.bytes;
        end else if (w_emit_nack) begin
            r_cnt <= r_cnt + CntW'(1);
            r_pos <= r_pos + 32'(w_nack_len);
            r_rem <= r_rem - 32'(w_nack_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_nack) begin
            r_out_kind  <= KIND_NACK;
            r_out_start <= r_pos;
            r_out_len   <= w_nack_len;
            r_out_ovf   <= r_ovf;
            r_out_last  <= 1'b0;
            r_out_pkts  <= r_pkts;
            r_out_bytes <= r_bytes;
        end else if (w_emit_final) begin
            r_out_kind  <= r_kind;
            r_out_start <= 32'd0;
            r_out_len   <= 16'd0;
            r_out_ovf   <= r_ovf;
            r_out_last  <= 1'b1;
            r_out_pkts  <= r_pkts;
            r_out_bytes <= r_bytes;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_range_start   = r_out_start;
    assign o_range_len     = r_out_len;
    assign o_nack_overflow = r_out_ovf;
    assign o_last_of_run   = r_out_last;
    assign o_packet_count  = r_out_pkts;
    assign o_byte_count    = r_out_bytes;

endmodule

// ===== sv/seq_gap_nack_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seq_gap_nack_generator - receiver-side loss detector with NACK ranges
// Tracks the expected byte offset of a sequenced multicast session, drops
// stale or foreign packets and reports gaps as chunked NACK ranges.
// ----------------------------------------------------------------------------
// The front part takes one request per cycle while its two-entry command
// queue has room; the back part loads a command, then emits its NACK
// ranges (up to MAX_NACKS_PER_ITEM) and the closing result, and loads no
// new command before that is done. Results leave through a registered
// output that accepts the next result in the cycle the current one is
// taken. Configure through the APB port only while no transaction is in
// flight.
// ----------------------------------------------------------------------------
module seq_gap_nack_generator
    import sgn_pkg::*;
#(
    parameter int MAX_NACKS_PER_ITEM = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_pkt_session,
    input  logic [31:0] i_pkt_seq,
    input  logic [15:0] i_pkt_len,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_result_kind,
    output logic [31:0] o_range_start,
    output logic [15:0] o_range_len,
    output logic        o_nack_overflow,
    output logic        o_last_of_run,
    output logic [31:0] o_packet_count,
    output logic [31:0] o_byte_count
);

    logic [31:0] r_exp_session;
    logic [31:0] r_xfer_size;
    logic [15:0] r_chunk_len;
    logic        w_wr;
    t_reg_idx    w_idx;

    logic        w_push;
    logic        w_pop;
    logic        w_q_full;
    logic        w_q_valid;
    t_cmd        w_push_cmd;
    t_cmd        w_q_cmd;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_session <= 32'd0;
            r_xfer_size   <= 32'd0;
            r_chunk_len   <= CHUNK_LEN_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SESSION:  r_exp_session <= pwdata;
                REG_XFER:     r_xfer_size   <= pwdata;
                REG_CHUNK:    r_chunk_len   <= pwdata[15:0];
                REG_RESERVED: r_chunk_len   <= r_chunk_len;
                default:      r_chunk_len   <= r_chunk_len;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SESSION:  prdata = r_exp_session;
            REG_XFER:     prdata = r_xfer_size;
            REG_CHUNK:    prdata = 32'(r_chunk_len);
            REG_RESERVED: prdata = 32'd0;
            default:      prdata = 32'd0;
        endcase
    end

    sgn_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_in_valid),
        .o_stall            (o_in_stall),
        .i_req_type         (i_req_type),
        .i_pkt_session      (i_pkt_session),
        .i_pkt_seq          (i_pkt_seq),
        .i_pkt_len          (i_pkt_len),
        .i_expected_session (r_exp_session),
        .i_transfer_size    (r_xfer_size),
        .i_q_full           (w_q_full),
        .o_push             (w_push),
        .o_cmd              (w_push_cmd)
    );

    sgn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    sgn_back #(
        .MAX_NACKS_PER_ITEM (MAX_NACKS_PER_ITEM)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_chunk_len     (r_chunk_len),
        .i_q_valid       (w_q_valid),
        .i_q_cmd         (w_q_cmd),
        .o_pop           (w_pop),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_result_kind   (o_result_kind),
        .o_range_start   (o_range_start),
        .o_range_len     (o_range_len),
        .o_nack_overflow (o_nack_overflow),
        .o_last_of_run   (o_last_of_run),
        .o_packet_count  (o_packet_count),
        .o_byte_count    (o_byte_count)
    );

endmodule

// ===== test/seq_gap_nack_generator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seq_gap_nack_generator_tb - self-checking bench for the NACK gap detector
// Drives data, finish, start and unused requests through the input channel,
// programs the three registers over APB between phases, and compares every
// result transaction field by field with a cycle-free model of the offset
// tracker, the gap splitter and the session counters.
// ----------------------------------------------------------------------------
module seq_gap_nack_generator_tb;
    import sgn_pkg::*;

    localparam int MAX_NACKS   = 63;
    localparam int SETTLE_CYC  = MAX_NACKS + 8;
    localparam int RX_HOLD     = 400;
    localparam int WDOG_LIMIT  = 3000;

    typedef struct {
        t_kind       kind;
        logic [31:0] start;
        logic [15:0] len;
        logic        ovf;
        logic        last;
        logic [31:0] pkts;
        logic [31:0] bytes;
    } t_report;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_req_type;
    logic [31:0] i_pkt_session;
    logic [31:0] i_pkt_seq;
    logic [15:0] i_pkt_len;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_result_kind;
    logic [31:0] o_range_start;
    logic [15:0] o_range_len;
    logic        o_nack_overflow;
    logic        o_last_of_run;
    logic [31:0] o_packet_count;
    logic [31:0] o_byte_count;

    // Mirror of the block's registers and session state
    logic [31:0] cfg_session;
    logic [31:0] cfg_xfer;
    logic [15:0] cfg_chunk;
    logic [31:0] next_offset;
    logic [31:0] pkt_total;
    logic [31:0] byte_total;

    logic [31:0] gap_start [MAX_NACKS];
    logic [15:0] gap_size  [MAX_NACKS];
    int          gap_n;
    logic        gap_ovf;

    t_report     due_reports[$];
    t_report     head;
    int          err_count;
    int          idle_cycles;
    bit          quiet;
    bit          rx_hold_req;

    seq_gap_nack_generator #(
        .MAX_NACKS_PER_ITEM(MAX_NACKS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_pkt_session  (i_pkt_session),
        .i_pkt_seq      (i_pkt_seq),
        .i_pkt_len      (i_pkt_len),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_kind  (o_result_kind),
        .o_range_start  (o_range_start),
        .o_range_len    (o_range_len),
        .o_nack_overflow(o_nack_overflow),
        .o_last_of_run  (o_last_of_run),
        .o_packet_count (o_packet_count),
        .o_byte_count   (o_byte_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Cut [from, to) into ranges of at most one chunk, keeping the first MAX_NACKS
    task automatic split_gap(input logic [31:0] from, input logic [31:0] to);
        logic [31:0]       piece;
        logic [31:0]       pos;
        logic [31:0]       rem;
        longint unsigned   span;
        longint unsigned   need;
        piece = (cfg_chunk == 16'd0) ? 32'd1 : {16'd0, cfg_chunk};
        span = longint'(to - from);
        need = (span + piece - 1) / piece;
        gap_ovf = (need > MAX_NACKS);
        gap_n = 0;
        pos = from;
        while (pos < to && gap_n < MAX_NACKS) begin
            rem = to - pos;
            if (rem > piece)
                rem = piece;
            gap_start[gap_n] = pos;
            gap_size[gap_n] = rem[15:0];
            pos = pos + rem;
            gap_n++;
        end
    endtask

    task automatic push_report(input t_kind kind, input logic [31:0] start,
                               input logic [15:0] len, input logic ovf,
                               input logic last);
        t_report rep;
        rep.kind = kind;
        rep.start = start;
        rep.len = len;
        rep.ovf = ovf;
        rep.last = last;
        rep.pkts = pkt_total;
        rep.bytes = byte_total;
        due_reports = {due_reports, rep};
    endtask

    task automatic track_request(input t_req req, input logic [31:0] sess,
                                 input logic [31:0] seq, input logic [15:0] len);
        gap_n = 0;
        gap_ovf = 1'b0;
        case (req)
            REQ_DATA: begin
                if (sess != cfg_session || seq < next_offset) begin
                    push_report(KIND_DROP, 32'd0, 16'd0, 1'b0, 1'b1);
                end else begin
                    if (seq > next_offset)
                        split_gap(next_offset, seq);
                    next_offset = seq + {16'd0, len};
                    pkt_total = pkt_total + 32'd1;
                    byte_total = byte_total + {16'd0, len};
                    for (int i = 0; i < gap_n; i++)
                        push_report(KIND_NACK, gap_start[i], gap_size[i], gap_ovf, 1'b0);
                    push_report(KIND_ACCEPT, 32'd0, 16'd0, gap_ovf, 1'b1);
                end
            end
            REQ_FINISH: begin
                if (cfg_xfer > next_offset)
                    split_gap(next_offset, cfg_xfer);
                for (int i = 0; i < gap_n; i++)
                    push_report(KIND_NACK, gap_start[i], gap_size[i], gap_ovf, 1'b0);
                push_report(KIND_END, 32'd0, 16'd0, gap_ovf, 1'b1);
            end
            REQ_START: begin
                next_offset = 32'd0;
                pkt_total = 32'd0;
                byte_total = 32'd0;
                push_report(KIND_START, 32'd0, 16'd0, 1'b0, 1'b1);
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_item(input t_req req, input logic [31:0] sess,
                             input logic [31:0] seq, input logic [15:0] len);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type <= req;
        i_pkt_session <= sess;
        i_pkt_seq <= seq;
        i_pkt_len <= len;
        i_in_valid <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall)
                break;
        end
        track_request(req, sess, seq, len);
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_reports.size() != 0)
            @(posedge i_clk);
    endtask

    // Drain, then allow for a range run still going after its last result
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_SESSION: cfg_session = data;
            REG_XFER:    cfg_xfer = data;
            REG_CHUNK:   cfg_chunk = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] sess, input logic [31:0] xfer,
                             input logic [15:0] chunk);
        settle();
        apb_write(REG_SESSION, sess);
        apb_write(REG_XFER, xfer);
        // upper bits of the chunk register are ignored
        apb_write(REG_CHUNK, {16'($urandom), chunk});
    endtask

    // Mostly well-formed traffic on the current session, with some noise
    task automatic send_mixed_item();
        int          r;
        logic [31:0] piece;
        logic [31:0] sess;
        logic [31:0] seq;
        logic [15:0] len;
        t_req        req;
        piece = (cfg_chunk == 16'd0) ? 32'd1 : {16'd0, cfg_chunk};
        r = $urandom_range(0, 99);
        req = REQ_DATA;
        sess = cfg_session;
        seq = next_offset;
        len = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1500));
        if (r < 58) begin
            // in order
        end else if (r < 72) begin
            if ($urandom_range(0, 5) == 0)
                seq = next_offset + piece * $urandom_range(5, 80);
            else
                seq = next_offset + $urandom_range(1, piece * 3);
        end else if (r < 78) begin
            if (next_offset != 32'd0)
                seq = $urandom_range(0, next_offset - 1);
        end else if (r < 84) begin
            sess = cfg_session ^ ($urandom | 32'd1);
        end else if (r < 88) begin
            req = REQ_FINISH;
            seq = $urandom;
        end else if (r < 91) begin
            req = REQ_START;
            sess = $urandom;
        end else if (r < 95) begin
            req = REQ_NONE;
            sess = $urandom;
            seq = $urandom;
        end else begin
            sess = ($urandom_range(0, 1) == 1) ? cfg_session : $urandom;
            seq = $urandom;
            len = 16'($urandom);
        end
        if ($urandom_range(0, 24) == 0)
            hold_until_drained();
        send_item(req, sess, seq, len);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    initial begin
        int run_left;
        int stall_left;
        int hold_left;
        run_left = 0;
        stall_left = 0;
        hold_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                hold_left = RX_HOLD;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else if (run_left > 0 || quiet) begin
                i_out_stall <= 1'b0;
                if (run_left > 0)
                    run_left--;
            end else begin
                run_left = $urandom_range(0, 24);
                stall_left = pick_gap();
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_reports.size() == 0) begin
                $display("%0t ns: result with nothing expected, kind %0d",
                         $time, o_result_kind);
                err_count++;
            end else begin
                head = due_reports.pop_front();
                check_field("result_kind", 32'(head.kind), 32'(o_result_kind));
                check_field("range_start", head.start, o_range_start);
                check_field("range_len", 32'(head.len), 32'(o_range_len));
                check_field("nack_overflow", 32'(head.ovf), 32'(o_nack_overflow));
                check_field("last_of_run", 32'(head.last), 32'(o_last_of_run));
                check_field("packet_count", head.pkts, o_packet_count);
                check_field("byte_count", head.bytes, o_byte_count);
            end
        end
    end

    // End the run if neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("%0t ns: no transaction for %0d cycles", $time, WDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_edges();
        // reset settings: session 0, no transfer size, chunk 1460
        send_item(REQ_START, 32'd0, 32'd0, 16'd0);
        send_item(REQ_DATA, 32'd0, 32'd0, 16'd100);
        send_item(REQ_DATA, 32'd0, 32'd100, 16'd0);
        send_item(REQ_DATA, 32'd0, 32'd50, 16'd10);
        send_item(REQ_DATA, 32'd1, 32'd100, 16'd10);
        send_item(REQ_DATA, 32'd0, 32'd3000, 16'hFFFF);
        send_item(REQ_NONE, $urandom, $urandom, 16'($urandom));
        send_item(REQ_FINISH, 32'd0, 32'd0, 16'd0);

        // widest gap: truncated, offset wraps past 2^32
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(REQ_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(REQ_DATA, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(REQ_DATA, 32'hFFFF_FFFF, 32'd65534, 16'd1);
        send_item(REQ_FINISH, 32'd0, 32'd0, 16'd0);

        // zero chunk length behaves as one byte
        configure(32'hA5A5_5A5A, 32'd10, 16'd0);
        send_item(REQ_START, 32'd0, 32'd0, 16'd0);
        send_item(REQ_DATA, 32'hA5A5_5A5A, 32'd5, 16'd3);
        send_item(REQ_FINISH, 32'd0, 32'd0, 16'd0);
        send_item(REQ_DATA, 32'hA5A5_5A5A, 32'd200, 16'd0);
        send_item(REQ_FINISH, 32'd0, 32'd0, 16'd0);

        // exactly the range limit, then one over
        configure(32'd0, 32'h8000_0000, 16'd1);
        send_item(REQ_START, 32'd0, 32'd0, 16'd0);
        send_item(REQ_DATA, 32'd0, 32'd63, 16'd1);
        send_item(REQ_DATA, 32'd0, 32'd128, 16'd1);
    endtask

    task automatic test_random_traffic();
        logic [31:0] sess;
        logic [15:0] chunk;
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: begin sess = 32'd0;         chunk = 16'd1;                      end
                1: begin sess = $urandom;      chunk = 16'hFFFF;                   end
                2: begin sess = $urandom;      chunk = 16'($urandom_range(1, 64)); end
                3: begin sess = $urandom;      chunk = CHUNK_LEN_RESET;            end
                default: begin sess = 32'hFFFF_FFFF; chunk = 16'($urandom);        end
            endcase
            configure(sess, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200000),
                      chunk);
            send_item(REQ_START, $urandom, $urandom, 16'($urandom));
            repeat (49) send_mixed_item();
        end
    endtask

    task automatic test_backpressure();
        configure(32'h1234_5678, 32'd4000, 16'd16);
        send_item(REQ_START, 32'd0, 32'd0, 16'd0);
        // hold the output while gapped packets keep arriving
        rx_hold_req = 1'b1;
        repeat (10)
            send_item(REQ_DATA, cfg_session, next_offset + 32'd80, 16'd10);
        hold_until_drained();
        send_item(REQ_DATA, cfg_session, next_offset + 32'd33, 16'd7);
        send_item(REQ_FINISH, 32'd0, 32'd0, 16'd0);
        send_item(REQ_DATA, cfg_session, next_offset, 16'd1);
    endtask

    task automatic test_streaming();
        quiet = 1'b1;
        repeat (25) begin
            if ($urandom_range(0, 4) == 0)
                send_item(REQ_DATA, cfg_session, next_offset + 32'd20, 16'($urandom));
            else
                send_item(REQ_DATA, cfg_session, next_offset, 16'($urandom_range(0, 1500)));
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_req_type = REQ_NONE;
        i_pkt_session = '0;
        i_pkt_seq = '0;
        i_pkt_len = '0;
        cfg_session = '0;
        cfg_xfer = '0;
        cfg_chunk = CHUNK_LEN_RESET;
        next_offset = '0;
        pkt_total = '0;
        byte_total = '0;
        err_count = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        rx_hold_req = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_random_traffic();
        test_backpressure();
        test_streaming();

        settle();
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
